@@ rtl/gif_lzw_code_stream_encoder_defines.svh @@
// Assertion macros for the LZW encoder.
`ifndef GIF_LZW_CODE_STREAM_ENCODER_DEFINES_SVH
`define GIF_LZW_CODE_STREAM_ENCODER_DEFINES_SVH

// Checked outside reset.
`define GLZW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GLZW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/glzw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package glzw_pkg;
	localparam int MAX_CODES   = 4096;
	localparam int MAX_SYMBOLS = 256;
	localparam int CODE_W      = $clog2(MAX_CODES);
	localparam int SYM_W       = $clog2(MAX_SYMBOLS) + 1;
	localparam int PIX_W       = 8;
	localparam int ADDR_W      = $clog2(MAX_CODES) + $clog2(MAX_SYMBOLS);
	localparam int CWID_W      = $clog2(CODE_W + 1);
	localparam int CQ_DEPTH    = 8;
	localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
	localparam int ACC_W       = CODE_W + 8;
	localparam int PEND_W      = $clog2(ACC_W + 1);
	localparam logic [CODE_W-1:0] FULL_LIMIT = CODE_W'(MAX_CODES - 2);

	localparam logic REG_CODE_SIZE    = 1'b0;
	localparam logic REG_SYMBOL_COUNT = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [CWID_W-1:0] width;
		logic              rst;
		logic              close;
	} code_ent_t;

	function automatic logic [CWID_W-1:0] bit_len(input logic [CODE_W-1:0] v);
		logic [CWID_W-1:0] n;
		n = '0;
		for (int i = 0; i < CODE_W; i++) begin
			if (v[i]) begin
				n = CWID_W'(i + 1);
			end
		end
		return n;
	endfunction
endpackage
`default_nettype wire

@@ rtl/gif_lzw_code_stream_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  | signals                          | payload
// s_axis   | tvalid tready tdata tuser tlast  | pixel_index, first_pixel, last_pixel
// m_axis   | tvalid tready tdata tlast        | out_byte, frame_end
// cfg      | valid ready index data           | code_size (0), symbol_count (1)
// A pixel passes through dictionary read, back-pointer check read, then decide and write.
// A first pixel, or a pixel with no open frame, is done in the idle state; the input register
// frees only as a pixel starts, so a new pixel is taken only once the held one has started.
// Codes queue up; the packer shifts in one code or, when the output slot is free, sends one byte per cycle.
// Reset clears control state; the dictionary needs no clearing pass.
// A pixel starts only with at most 4 codes queued, so m_axis stalls back up into s_axis.
module gif_lzw_code_stream_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] pixel_index
	input  wire logic       s_axis_tuser,   // [0] first_pixel
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
	output logic            m_axis_tlast,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [8:0] cfg_data
);
	`include "gif_lzw_code_stream_encoder_defines.svh"

	localparam int CW = glzw_pkg::CODE_W;
	localparam int AW = glzw_pkg::ADDR_W;
	localparam int SW = glzw_pkg::SYM_W;
	localparam int WW = glzw_pkg::CWID_W;
	localparam int PW = glzw_pkg::CQ_PTR_W;

	typedef enum logic [1:0] {S_IDLE, S_BK, S_DEC} state_t;

	state_t state_q;
	logic [3:0]    cs_q;
	logic [SW-1:0] sc_q;
	logic ib_valid_q, ib_first_q, ib_last_q;
	logic [glzw_pkg::PIX_W-1:0] ib_pix_q;
	logic [CW-1:0] next_q, base_q, prefix_q, code_q, clr_q, pix_q;
	logic [AW-1:0] addr_q;
	logic last_q, rng_q;

	logic [CW-1:0] dict_mem [2**AW];
	logic [AW-1:0] back_mem [2**CW];
	logic [CW-1:0] dict_rd_q;
	logic [AW-1:0] back_rd_q;

	glzw_pkg::code_ent_t cq_mem_q [glzw_pkg::CQ_DEPTH];
	logic [PW-1:0] cq_wr_q, cq_rd_q;
	logic [PW:0]   cq_cnt_q;

	logic [glzw_pkg::ACC_W-1:0]  acc_q;
	logic [glzw_pkg::PEND_W-1:0] pend_q;
	logic closing_q;
	logic out_valid_q, out_last_q;
	logic [7:0] out_data_q;

	logic [3:0]    cs_c;
	logic [SW-1:0] stride_c;
	logic [CW-1:0] pix_c, clr_c;
	logic [CW+SW-1:0] prod_c;
	logic [AW-1:0] rd_addr_c;
	logic start_c, hit_c, we_c, clear_c;
	logic [CW-1:0] nx_c, pf_c;
	glzw_pkg::code_ent_t ent_c [4];
	logic [2:0] push_n_c;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !ib_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		cs_c = cs_q;
		if (cs_q < 4'd1) cs_c = 4'd1;
		if (cs_q > 4'd8) cs_c = 4'd8;
		stride_c = sc_q;
		if (sc_q < SW'(2)) stride_c = SW'(2);
		if (sc_q > SW'(glzw_pkg::MAX_SYMBOLS)) stride_c = SW'(glzw_pkg::MAX_SYMBOLS);
		pix_c = CW'(ib_pix_q);
		if (CW'(ib_pix_q) >= CW'(stride_c)) pix_c = CW'(stride_c) - CW'(1);
		clr_c = CW'(1) << cs_c;
		prod_c = (CW+SW)'(prefix_q) * (CW+SW)'(stride_c) + (CW+SW)'(pix_c);
		rd_addr_c = prod_c[AW-1:0];
	end

	assign start_c = (state_q == S_IDLE) && ib_valid_q && (cq_cnt_q <= (PW+1)'(4));
	assign hit_c   = rng_q && (back_rd_q == addr_q);

	always_comb begin
		logic [2:0] n;
		n = '0;
		for (int i = 0; i < 4; i++) ent_c[i] = '0;
		we_c = 1'b0;
		clear_c = 1'b0;
		nx_c = next_q;
		pf_c = prefix_q;
		if (start_c && ib_first_q) begin
			nx_c = clr_c + CW'(2);
			pf_c = pix_c;
			ent_c[0] = '{code: clr_c, width: glzw_pkg::bit_len(clr_c + CW'(1)),
				rst: 1'b1, close: 1'b0};
			n = 3'd1;
			if (ib_last_q) begin
				ent_c[1] = '{code: pix_c, width: glzw_pkg::bit_len(nx_c - CW'(1)),
					rst: 1'b0, close: 1'b0};
				ent_c[2] = '{code: clr_c + CW'(1), width: glzw_pkg::bit_len(nx_c),
					rst: 1'b0, close: 1'b1};
				n = 3'd3;
			end
		end else if (state_q == S_DEC) begin
			if (hit_c) begin
				pf_c = code_q;
			end else begin
				ent_c[0] = '{code: prefix_q, width: glzw_pkg::bit_len(next_q - CW'(1)),
					rst: 1'b0, close: 1'b0};
				n = 3'd1;
				if (next_q > glzw_pkg::FULL_LIMIT) begin
					ent_c[1] = '{code: clr_q, width: glzw_pkg::bit_len(next_q - CW'(1)),
						rst: 1'b0, close: 1'b0};
					n = 3'd2;
					clear_c = 1'b1;
					nx_c = clr_q + CW'(2);
				end else begin
					we_c = 1'b1;
					nx_c = next_q + CW'(1);
				end
				pf_c = pix_q;
			end
			if (last_q) begin
				ent_c[n[1:0]] = '{code: pf_c, width: glzw_pkg::bit_len(nx_c - CW'(1)),
					rst: 1'b0, close: 1'b0};
				ent_c[2'(n + 3'd1)] = '{code: clr_q + CW'(1),
					width: glzw_pkg::bit_len(nx_c), rst: 1'b0, close: 1'b1};
				n = n + 3'd2;
			end
		end
		push_n_c = n;
	end

	always_ff @(posedge clk) begin
		dict_rd_q <= dict_mem[rd_addr_c];
		back_rd_q <= back_mem[dict_rd_q];
		if (we_c) begin
			dict_mem[addr_q] <= next_q;
			back_mem[next_q] <= addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start_c) begin
			addr_q <= rd_addr_c;
			pix_q  <= pix_c;
			clr_q  <= clr_c;
			last_q <= ib_last_q;
		end
		if (state_q == S_BK) begin
			code_q <= dict_rd_q;
			rng_q  <= (dict_rd_q >= base_q) && (dict_rd_q < next_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cs_q       <= 4'd8;
			sc_q       <= SW'(glzw_pkg::MAX_SYMBOLS);
			ib_valid_q <= 1'b0;
			ib_first_q <= 1'b0;
			ib_last_q  <= 1'b0;
			ib_pix_q   <= '0;
			next_q     <= '0;
			base_q     <= '0;
			prefix_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					glzw_pkg::REG_CODE_SIZE:    cs_q <= cfg_data[3:0];
					glzw_pkg::REG_SYMBOL_COUNT: sc_q <= cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				ib_valid_q <= 1'b1;
				ib_pix_q   <= s_axis_tdata;
				ib_first_q <= s_axis_tuser;
				ib_last_q  <= s_axis_tlast;
			end
			case (state_q)
				S_IDLE: begin
					if (start_c) begin
						ib_valid_q <= 1'b0;
						if (ib_first_q) begin
							base_q   <= nx_c;
							next_q   <= ib_last_q ? '0 : nx_c;
							prefix_q <= ib_last_q ? '0 : pf_c;
						end else if (next_q != '0) begin
							state_q <= S_BK;
						end
					end
				end
				S_BK: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					state_q  <= S_IDLE;
					next_q   <= last_q ? '0 : nx_c;
					prefix_q <= last_q ? '0 : pf_c;
					if (clear_c) begin
						base_q <= nx_c;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	glzw_pkg::code_ent_t head_c;
	logic [CW-1:0] mask_c;
	logic [glzw_pkg::ACC_W-1:0] ins_c;
	logic slot_c, emit_c, absorb_c;

	assign head_c   = cq_mem_q[cq_rd_q];
	assign mask_c   = head_c.code & ~({CW{1'b1}} << head_c.width);
	assign ins_c    = glzw_pkg::ACC_W'(mask_c) << pend_q;
	assign slot_c   = !out_valid_q || m_axis_tready;
	assign emit_c   = slot_c && ((pend_q >= glzw_pkg::PEND_W'(8)) ||
		(closing_q && pend_q != '0));
	assign absorb_c = (pend_q < glzw_pkg::PEND_W'(8)) && !closing_q && (cq_cnt_q != '0);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < push_n_c) begin
				cq_mem_q[PW'(cq_wr_q + PW'(i))] <= ent_c[i];
			end
		end
		if (emit_c) begin
			out_data_q <= acc_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cq_wr_q     <= '0;
			cq_rd_q     <= '0;
			cq_cnt_q    <= '0;
			acc_q       <= '0;
			pend_q      <= '0;
			closing_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			cq_wr_q  <= cq_wr_q + PW'(push_n_c);
			cq_rd_q  <= cq_rd_q + PW'(absorb_c);
			cq_cnt_q <= cq_cnt_q + (PW+1)'(push_n_c) - (PW+1)'(absorb_c);
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_c) begin
				out_valid_q <= 1'b1;
				if (pend_q >= glzw_pkg::PEND_W'(8)) begin
					acc_q      <= acc_q >> 8;
					pend_q     <= pend_q - glzw_pkg::PEND_W'(8);
					out_last_q <= closing_q && (pend_q == glzw_pkg::PEND_W'(8));
					if (closing_q && pend_q == glzw_pkg::PEND_W'(8)) begin
						closing_q <= 1'b0;
					end
				end else begin
					acc_q      <= '0;
					pend_q     <= '0;
					out_last_q <= 1'b1;
					closing_q  <= 1'b0;
				end
			end else if (closing_q && pend_q == '0) begin
				closing_q <= 1'b0;
			end else if (absorb_c) begin
				if (head_c.rst) begin
					acc_q  <= glzw_pkg::ACC_W'(mask_c);
					pend_q <= glzw_pkg::PEND_W'(head_c.width);
				end else begin
					acc_q  <= acc_q | ins_c;
					pend_q <= pend_q + glzw_pkg::PEND_W'(head_c.width);
				end
				closing_q <= head_c.close;
			end
		end
	end

	`GLZW_ASSERT(a_cq_bound, cq_cnt_q <= (PW+1)'(glzw_pkg::CQ_DEPTH), "code queue overrun")
	`GLZW_ASSERT(a_pend_bound, pend_q < glzw_pkg::PEND_W'(glzw_pkg::ACC_W), "bit accumulator overrun")
	`GLZW_ASSERT(a_next_base, (next_q != '0) |-> (next_q >= base_q), "next code below first code")
	`GLZW_ASSERT(a_dec_from_bk, (state_q == S_DEC) |-> ($past(state_q) == S_BK), "decide without lookup")
endmodule
`default_nettype wire

@@ test/tb_gif_lzw_code_stream_encoder.sv @@
`timescale 1ns / 1ps
module tb_gif_lzw_code_stream_encoder;

	typedef struct {
		logic [7:0] out_byte;
		logic       frame_end;
	} enc_byte_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tuser;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [8:0] cfg_data;

	gif_lzw_code_stream_encoder u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// encoder shadow state
	logic [3:0]  mdl_code_size;
	logic [8:0]  mdl_symbol_count;
	logic [11:0] dict_code [int];
	int unsigned mdl_next_code;
	int unsigned mdl_prefix;
	logic [31:0] mdl_acc;
	int unsigned mdl_pend;
	int          byte_cnt;

	enc_byte_t   stream_q[$];
	int          mismatches;
	int          stall_cycles;
	bit          idle_en;
	bit          hold_start;
	int          hold_left;
	int          pixels_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned code_len(int unsigned v);
		int unsigned n;
		n = 0;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	function automatic void pack_code(int unsigned code, int unsigned width);
		enc_byte_t b;
		if (width > 16) width = 16;
		code &= (32'd1 << width) - 1;
		mdl_acc |= code << mdl_pend;
		mdl_pend += width;
		while (mdl_pend >= 8) begin
			if (byte_cnt < 8) begin
				b.out_byte  = mdl_acc[7:0];
				b.frame_end = 1'b0;
				stream_q.push_back(b);
				byte_cnt++;
			end
			mdl_acc >>= 8;
			mdl_pend -= 8;
		end
	endfunction

	function automatic void encode_pixel(logic [7:0] pix_in, logic first, logic last);
		int unsigned cs, stride, pix, clr, addr, width;
		enc_byte_t b;
		cs = 32'(mdl_code_size);
		stride = 32'(mdl_symbol_count);
		pix = 32'(pix_in);
		byte_cnt = 0;
		if (cs < 1) cs = 1;
		if (cs > 8) cs = 8;
		if (stride < 2) stride = 2;
		if (stride > glzw_pkg::MAX_SYMBOLS) stride = glzw_pkg::MAX_SYMBOLS;
		if (pix >= stride) pix = stride - 1;
		clr = 1 << cs;
		if (first) begin
			dict_code.delete();
			mdl_acc = '0;
			mdl_pend = 0;
			mdl_next_code = clr + 2;
			pack_code(clr, code_len(mdl_next_code - 1));
			mdl_prefix = pix;
		end else begin
			if (mdl_next_code == 0) return;
			addr = (mdl_prefix % glzw_pkg::MAX_CODES) * stride + pix;
			if (dict_code.exists(addr)) begin
				mdl_prefix = 32'(dict_code[addr]);
			end else begin
				width = code_len(mdl_next_code - 1);
				pack_code(mdl_prefix, width);
				if (mdl_next_code > glzw_pkg::MAX_CODES - 2) begin
					pack_code(clr, width);
					dict_code.delete();
					mdl_next_code = clr + 2;
				end else begin
					dict_code[addr] = mdl_next_code[11:0];
					mdl_next_code++;
				end
				mdl_prefix = pix;
			end
		end
		if (last) begin
			pack_code(mdl_prefix, code_len(mdl_next_code - 1));
			pack_code(clr + 1, code_len(mdl_next_code));
			if (mdl_pend > 0 && byte_cnt < 8) begin
				b.out_byte  = mdl_acc[7:0];
				b.frame_end = 1'b0;
				stream_q.push_back(b);
				byte_cnt++;
			end
			mdl_acc = '0;
			mdl_pend = 0;
			if (byte_cnt > 0) stream_q[$].frame_end = 1'b1;
			mdl_next_code = 0;
			mdl_prefix = 0;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		enc_byte_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (stream_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected byte %h last %b", m_axis_tdata, m_axis_tlast);
			end else begin
				e = stream_q.pop_front();
				if (e.out_byte !== m_axis_tdata || e.frame_end !== m_axis_tlast) begin
					mismatches++;
					if (mismatches <= 10)
						$display("byte mismatch: exp %h/%b got %h/%b", e.out_byte,
							e.frame_end, m_axis_tdata, m_axis_tlast);
				end
			end
		end
	end

	// receiver: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (hold_start) begin
			hold_start = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !idle_en || ($urandom_range(99) >= 26);
		end
	end

	// watchdog on transfer activity
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready) || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= 20000) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_pixel(input logic [7:0] pix, input logic first, input logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= first;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		encode_pixel(pix, first, last);
		pixels_sent++;
		if (idle_en && $urandom_range(99) < 26) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (stream_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == glzw_pkg::REG_CODE_SIZE) mdl_code_size = val[3:0];
		else mdl_symbol_count = val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [8:0] cs, input logic [8:0] sc);
		wait_idle();
		write_reg(glzw_pkg::REG_CODE_SIZE, cs);
		write_reg(glzw_pkg::REG_SYMBOL_COUNT, sc);
	endtask

	task automatic test_directed_frames();
		send_pixel(8'd5, 1'b0, 1'b0);     // no frame open: ignored
		send_pixel(8'd0, 1'b1, 1'b0);
		send_pixel(8'd0, 1'b0, 1'b0);
		send_pixel(8'd0, 1'b0, 1'b0);
		send_pixel(8'd0, 1'b0, 1'b0);
		send_pixel(8'd255, 1'b0, 1'b0);
		send_pixel(8'd170, 1'b0, 1'b0);
		send_pixel(8'd85, 1'b0, 1'b1);
		send_pixel(8'd7, 1'b0, 1'b1);     // after frame end: ignored
		send_pixel(8'd9, 1'b1, 1'b1);     // single-pixel frame
		send_pixel(8'd1, 1'b1, 1'b0);
		send_pixel(8'd2, 1'b0, 1'b0);
		send_pixel(8'd3, 1'b1, 1'b0);     // restart inside open frame
		send_pixel(8'd3, 1'b0, 1'b1);
	endtask

	task automatic test_config_extremes();
		set_config(9'd1, 9'd2);
		send_pixel(8'd0, 1'b1, 1'b0);
		send_pixel(8'd255, 1'b0, 1'b0);   // saturates to symbol count - 1
		send_pixel(8'd1, 1'b0, 1'b0);
		send_pixel(8'd1, 1'b0, 1'b1);
		set_config(9'd0, 9'd0);
		send_pixel(8'd1, 1'b1, 1'b0);
		send_pixel(8'd0, 1'b0, 1'b1);
		set_config(9'd15, 9'd511);
		send_pixel(8'd200, 1'b1, 1'b0);
		send_pixel(8'd255, 1'b0, 1'b1);
	endtask

	task automatic random_frame(input int len);
		int alpha;
		logic [7:0] pix;
		alpha = ($urandom_range(3) == 0) ? 255 : $urandom_range(1, 6);
		pix = 8'($urandom_range(alpha));
		send_pixel(pix, 1'b1, len == 1);
		for (int i = 1; i < len; i++) begin
			if ($urandom_range(2) != 0) pix = 8'($urandom_range(alpha));
			send_pixel(pix, $urandom_range(39) == 0, i == len - 1);
		end
		if ($urandom_range(9) == 0) send_pixel(8'($urandom), 1'b0, 1'($urandom_range(1)));
	endtask

	task automatic test_random_frames();
		logic [8:0] sc;
		int target;
		bit calm;
		target = pixels_sent + 300;
		calm = 1'b1;
		while (pixels_sent < target) begin
			case ($urandom_range(4))
				0: sc = 9'd2;
				1: sc = 9'd256;
				2: sc = 9'($urandom_range(511));
				default: sc = 9'($urandom_range(2, 16));
			endcase
			set_config(9'($urandom_range(15)), sc);
			idle_en = !calm && ($urandom_range(4) != 0);
			repeat (4) random_frame(calm ? 25 : $urandom_range(1, 25));
			calm = 1'b0;
		end
		idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		set_config(9'd2, 9'd4);
		hold_start = 1'b1;
		random_frame(60);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = glzw_pkg::REG_CODE_SIZE;
		cfg_data = '0;
		mismatches = 0;
		stall_cycles = 0;
		idle_en = 1'b1;
		hold_start = 1'b0;
		hold_left = 0;
		pixels_sent = 0;
		mdl_code_size = 4'd8;
		mdl_symbol_count = 9'd256;
		mdl_next_code = 0;
		mdl_prefix = 0;
		mdl_acc = '0;
		mdl_pend = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_config_extremes();
		test_backpressure();
		test_random_frames();

		wait_idle();
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

@@ gif_lzw_code_stream_encoder.f @@
+incdir+rtl
rtl/glzw_pkg.sv
rtl/gif_lzw_code_stream_encoder.sv
test/tb_gif_lzw_code_stream_encoder.sv
